// File: hdl/pit_pkg.sv
// Shared types and codes for the point intern table.
package pit_pkg;
    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch input word, clear scan index
        logic rd;        // read entry at scan index
        logic step;      // advance scan index
        logic wr;        // append latched point
        logic finish;    // load the result registers and done
    } pit_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic at_end;    // scan index reached entry count
        logic full;      // count equals capacity
        logic hit;       // registered entry matches
    } pit_sts_t;

    localparam logic [63:0] ABS_MASK = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] EXP_INF  = 64'h7FF0_0000_0000_0000;

    function automatic logic fp_eq(input logic [63:0] a, input logic [63:0] b);
        logic na;
        logic nb;
        na = (a & ABS_MASK) > EXP_INF;
        nb = (b & ABS_MASK) > EXP_INF;
        fp_eq = !na && !nb &&
                ((a == b) || (((a & ABS_MASK) == '0) && ((b & ABS_MASK) == '0)));
    endfunction
endpackage

// File: hdl/pit_ctrl.sv
// Sequencer for the search-then-append walk.
module pit_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output pit_pkg::pit_cmd_t cmd,
    input  pit_pkg::pit_sts_t sts
);
    import pit_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (sts.at_end)
                begin
                    cmd.wr = !sts.full;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (sts.hit)
                    state_next = S_DONE;
                else
                begin
                    cmd.step = 1'b1;
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// File: hdl/pit_dp.sv
// Point store, scan index, compare and result registers.
module pit_dp #(
    parameter int CAPACITY = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [63:0]       x_value,
    input  logic [63:0]       y_value,
    input  pit_pkg::pit_cmd_t cmd,
    output pit_pkg::pit_sts_t sts,
    output logic              done,
    output logic [7:0]        point_index,
    output logic [1:0]        status
);
    import pit_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    logic [63:0] x_mem [CAPACITY];
    logic [63:0] y_mem [CAPACITY];

    logic [63:0]   x_reg, y_reg, xr_reg, yr_reg;
    logic [CW-1:0] count_reg, idx_reg;
    logic          done_reg;
    logic [7:0]    pidx_reg;
    status_t       status_reg;
    logic          hit;
    logic [CW+7:0] idx_ext;

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            xr_reg <= x_mem[idx_reg[AW-1:0]];
            yr_reg <= y_mem[idx_reg[AW-1:0]];
        end
        if (cmd.wr)
        begin
            x_mem[count_reg[AW-1:0]] <= x_reg;
            y_mem[count_reg[AW-1:0]] <= y_reg;
        end
        if (cmd.load)
        begin
            x_reg <= x_value;
            y_reg <= y_value;
        end
    end

    assign hit = fp_eq(xr_reg, x_reg) && fp_eq(yr_reg, y_reg);
    assign idx_ext = {8'd0, idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            idx_reg    <= '0;
            done_reg   <= 1'b0;
            pidx_reg   <= '0;
            status_reg <= ST_FOUND;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.load)
                idx_reg <= '0;
            if (cmd.step)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.finish)
            begin
                // idx stops at the hit, or at count on a miss
                if (idx_reg != count_reg)
                begin
                    status_reg <= ST_FOUND;
                    pidx_reg   <= idx_ext[7:0];
                end
                else if (count_reg == CAP)
                begin
                    status_reg <= ST_FULL;
                    pidx_reg   <= '0;
                end
                else
                begin
                    // entry was written at the end of the scan; count it now
                    status_reg <= ST_INSERTED;
                    pidx_reg   <= idx_ext[7:0];
                    count_reg  <= count_reg + 1'b1;
                end
            end
        end
    end

    assign sts.at_end = (idx_reg == count_reg);
    assign sts.full   = (count_reg == CAP);
    assign sts.hit    = hit;
    assign done        = done_reg;
    assign point_index = pidx_reg;
    assign status      = status_reg;
endmodule

// File: hdl/point_intern_table_unit.sv
// Point intern table: finds a 2-D point among stored ones or appends it.
// Each lookup does one store read and one compare per entry, stopping at a hit
// or after the last stored entry. One word at a time; busy stays high until done.
// Reset empties the table; entry contents are not cleared.
module point_intern_table_unit #(
    parameter int CAPACITY = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] x_value,
    input  logic [63:0] y_value,
    output logic        done,
    output logic [7:0]  point_index,
    output logic [1:0]  status
);
    import pit_pkg::*;

    pit_cmd_t cmd;
    pit_sts_t sts;

    pit_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    pit_dp #(.CAPACITY(CAPACITY)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .x_value     (x_value),
        .y_value     (y_value),
        .cmd         (cmd),
        .sts         (sts),
        .done        (done),
        .point_index (point_index),
        .status      (status)
    );
endmodule

// File: verif/tb_top.sv
// Testbench for the point intern table: directed and random lookups checked by a scoreboard.
`timescale 1ns / 100ps

module tb_top;
    import pit_pkg::*;

    localparam int TABLE_SIZE = 256;
    localparam int STALL_LIMIT = 4 * (2 * TABLE_SIZE + 4) + 200;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [63:0] x_value;
    logic [63:0] y_value;
    logic        done;
    logic [7:0]  point_index;
    logic [1:0]  status;

    typedef struct {
        logic [7:0] index;
        status_t    code;
    } lookup_t;

    class point_scoreboard;
        logic [63:0] xs[TABLE_SIZE];
        logic [63:0] ys[TABLE_SIZE];
        int          count;
        lookup_t     pending[$];
        int          errors;
        int          n_found;
        int          n_inserted;
        int          n_full;

        function new();
            count = 0;
            errors = 0;
            n_found = 0;
            n_inserted = 0;
            n_full = 0;
        endfunction

        function bit same_value(logic [63:0] a, logic [63:0] b);
            bit a_nan;
            bit b_nan;
            a_nan = (a & 64'h7FFF_FFFF_FFFF_FFFF) > 64'h7FF0_0000_0000_0000;
            b_nan = (b & 64'h7FFF_FFFF_FFFF_FFFF) > 64'h7FF0_0000_0000_0000;
            if (a_nan || b_nan)
                return 0;
            if (a == b)
                return 1;
            return (a[62:0] == '0) && (b[62:0] == '0);
        endfunction

        function void note_word(logic [63:0] x, logic [63:0] y);
            lookup_t r;
            for (int i = 0; i < count; i++)
            begin
                if (same_value(xs[i], x) && same_value(ys[i], y))
                begin
                    r.index = i[7:0];
                    r.code = ST_FOUND;
                    pending.push_back(r);
                    return;
                end
            end
            if (count >= TABLE_SIZE)
            begin
                r.index = 8'd0;
                r.code = ST_FULL;
            end
            else
            begin
                xs[count] = x;
                ys[count] = y;
                r.index = count[7:0];
                r.code = ST_INSERTED;
                count++;
            end
            pending.push_back(r);
        endfunction

        function void check_word(logic [7:0] idx, logic [1:0] st);
            lookup_t r;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected: index %0d status %0d", idx, st);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (idx !== r.index)
            begin
                $error("point_index: expected %0d, actual %0d", r.index, idx);
                errors++;
            end
            if (st !== r.code)
            begin
                $error("status: expected %0d, actual %0d", r.code, st);
                errors++;
            end
            case (r.code)
                ST_FOUND: n_found++;
                ST_INSERTED: n_inserted++;
                default: n_full++;
            endcase
        endfunction
    endclass

    point_scoreboard sb;
    int  idle_cycles;
    bit  stalls_on;
    logic [63:0] used_x[$];
    logic [63:0] used_y[$];

    point_intern_table_unit #(.CAPACITY(TABLE_SIZE)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .x_value(x_value),
        .y_value(y_value),
        .done(done),
        .point_index(point_index),
        .status(status)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_word(point_index, status);
    end

    // watchdog: cycles without any accepted word
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("point_intern_table_unit test failed");
            $finish;
        end
    end

    task automatic send_point(logic [63:0] x, logic [63:0] y);
        int gap;
        if (stalls_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        x_value <= x;
        y_value <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_word(x, y);
        used_x.push_back(x);
        used_y.push_back(y);
        start <= 1'b0;
        // wait out the search so the next start lands on an idle block
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [63:0] pick_coord(int which);
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = 64'h0;
            1: v = 64'h8000_0000_0000_0000;
            2: v = 64'h7FF8_0000_0000_0000 | {32'h0, $urandom};
            3: v = 64'h7FF0_0000_0000_0000 | {($urandom_range(0, 1) == 1), 63'h0};
            4, 5, 6:
            begin
                if (used_x.size() > 0)
                begin
                    v = which ? used_y[$urandom_range(0, used_y.size() - 1)]
                              : used_x[$urandom_range(0, used_x.size() - 1)];
                    if ($urandom_range(0, 3) == 0)
                        v[63] = ~v[63];
                end
                else
                    v = {$urandom, $urandom};
            end
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    initial
    begin
        sb = new();
        idle_cycles = 0;
        stalls_on = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        x_value = '0;
        y_value = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, signed zeros, NaN, infinities, repeats
        send_point(64'h0, 64'h0);
        send_point(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_point(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_point(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_point(64'h7FF8_0000_0000_0000, 64'h0);
        send_point(64'h0, 64'h7FF0_0000_0000_0001);
        send_point(64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000);
        send_point(64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000);
        send_point(64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000);
        send_point(64'h3FF0_0000_0000_0000, 64'h0);
        send_point(64'h3FF0_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_point(64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001);
        send_point(64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001);
        send_point(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);

        // random: fill the table, then mostly lookups and full misses
        for (int n = 0; n < 1600; n++)
        begin
            if (n >= 1450)
                stalls_on = 1'b0;
            send_point(pick_coord(0), pick_coord(1));
        end

        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d hits, %0d inserts, %0d full misses",
                 sb.n_found, sb.n_inserted, sb.n_full);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("point_intern_table_unit test passed");
        else
            $display("point_intern_table_unit test failed");
        $finish;
    end
endmodule

// File: files.f
hdl/pit_pkg.sv
hdl/pit_ctrl.sv
hdl/pit_dp.sv
hdl/point_intern_table_unit.sv
verif/tb_top.sv
